### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sle_pkg.sv
// ---------------------------------------------------------------------------
// String literal unescape package
// Character codes, result record and escape lookup functions.
// ---------------------------------------------------------------------------
package sle_pkg;

   localparam logic [7:0] CHR_BACKSLASH = 8'd92;
   localparam logic [7:0] CHR_ZERO      = 8'h30;
   localparam logic [7:0] CHR_X         = 8'h78;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_ESCAPE    = 8'd27;
   localparam int unsigned HEX_BITS     = 64;
   localparam int unsigned DIGIT_BITS   = 4;   // log2 of radix 16

   // One result record.
   typedef struct packed {
      logic       last;
      logic       bad;
      logic       has;
      logic [7:0] data;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } esc_type;

   typedef struct packed {
      logic                  valid;
      logic [DIGIT_BITS-1:0] value;
   } digit_type;

   // Simple escape letter to character code.
   function automatic esc_type simple_escape(input logic [7:0] c);
      esc_type r;
      r.valid = 1'b1;
      r.value = c;
      case (c)
         8'd39:  r.value = 8'd39;
         8'd34:  r.value = 8'd34;
         8'd92:  r.value = 8'd92;
         8'h61:  r.value = 8'd7;
         8'h62:  r.value = 8'd8;
         8'h65:  r.value = CHR_ESCAPE;
         8'h66:  r.value = 8'd12;
         8'h6e:  r.value = 8'd10;
         8'h72:  r.value = 8'd13;
         8'h74:  r.value = 8'd9;
         8'h76:  r.value = 8'd11;
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

   // Hex digit decode, either case.
   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type r;
      logic [7:0] t;
      r.valid = 1'b0;
      r.value = '0;
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.valid = 1'b1;
         t = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.valid = 1'b1;
         t = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.valid = 1'b1;
         t = c - 8'h37;
      end
      r.value = t[DIGIT_BITS-1:0];
      return r;
   endfunction

endpackage

### hdl/string_literal_unescape.sv
// ---------------------------------------------------------------------------
// String literal unescape
// Decodes the escape sequences of a quoted string token, one byte a transfer.
// ---------------------------------------------------------------------------
// Usage:
//  - req_*: raw token bytes, opening quote first; req_tlast marks the closing
//    quote. Both quotes are dropped.
//  - rsp_*: decoded characters. rsp_tuser[0] is set when rsp_tdata carries a
//    character; clear only on the end marker, which also raises rsp_tlast.
//    rsp_tuser[1] flags a space that stands in for an illegal escape.
//  - An input byte gives zero, one or two results. It sits in an input
//    register, and a short decode feeds the registered result that drives
//    rsp_tvalid and the other rsp_* outputs.
//  - Throughput is one byte per cycle while rsp_tready stays high; a byte that
//    gives two results holds the input register until its second result is
//    taken, since the result register takes one record a cycle.
//  - A stalled rsp_tready holds the result register and, once the input
//    register has work pending, deasserts req_tready.
//  - Synchronous reset clears the valid flags and the decode state; the next
//    byte is taken as an opening quote. req_tready is already high when reset
//    is released.
// ---------------------------------------------------------------------------
module string_literal_unescape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] has_byte, [1] bad_escape
   output logic       rsp_tlast
);
   import sle_pkg::*;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_ZERO,
      MODE_HEX
   } mode_type;

   localparam rsp_type RSP_END = '{last: 1'b1, bad: 1'b0, has: 1'b0, data: 8'd0};
   localparam rsp_type RSP_BAD = '{last: 1'b0, bad: 1'b1, has: 1'b1, data: CHR_SPACE};

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       phase_ff,  phase_in;

   // Decode state
   mode_type              mode_ff,     mode_in;
   logic                  at_start_ff, at_start_in;
   logic [HEX_BITS-1:0]   hex_ff,      hex_in;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Decode outputs
   logic [1:0] count;
   rsp_type    res0, res1, res_sel;
   esc_type    esc;
   digit_type  dig;

   logic out_free, emit, consume;

   function automatic rsp_type data_rsp(input logic [7:0] c);
      rsp_type r;
      r.last = 1'b0;
      r.bad  = 1'b0;
      r.has  = 1'b1;
      r.data = c;
      return r;
   endfunction

   // Work out every result of the held byte and the state it leaves.
   always_comb begin
      esc         = simple_escape(in_byte_ff);
      dig         = hex_digit(in_byte_ff);
      count       = 2'd0;
      res0        = RSP_END;
      res1        = RSP_END;
      mode_in     = mode_ff;
      at_start_in = at_start_ff;
      hex_in      = hex_ff;
      if (at_start_ff) begin
         // Drop the opening quote; a one-byte token gives only the end marker.
         at_start_in = 1'b0;
         if (in_last_ff) begin
            count       = 2'd1;
            at_start_in = 1'b1;
            mode_in     = MODE_PLAIN;
            hex_in      = '0;
         end
      end else if (in_last_ff) begin
         // Closing quote: flush any pending escape, then the end marker.
         case (mode_ff)
            MODE_ESC, MODE_ZERO: begin
               count = 2'd2;
               res0  = RSP_BAD;
            end
            MODE_HEX: begin
               count = 2'd2;
               res0  = data_rsp(hex_ff[7:0]);
            end
            default: count = 2'd1;
         endcase
         at_start_in = 1'b1;
         mode_in     = MODE_PLAIN;
         hex_in      = '0;
      end else begin
         case (mode_ff)
            MODE_PLAIN: begin
               if (in_byte_ff == CHR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  count = 2'd1;
                  res0  = data_rsp(in_byte_ff);
               end
            end
            MODE_ESC: begin
               if (esc.valid) begin
                  count   = 2'd1;
                  res0    = data_rsp(esc.value);
                  mode_in = MODE_PLAIN;
               end else if (in_byte_ff == CHR_ZERO) begin
                  mode_in = MODE_ZERO;
               end else begin
                  count   = 2'd1;
                  res0    = RSP_BAD;
                  mode_in = MODE_PLAIN;
               end
            end
            MODE_ZERO: begin
               if (in_byte_ff == CHR_X) begin
                  mode_in = MODE_HEX;
                  hex_in  = '0;
               end else begin
                  // Backslash 0 without x is illegal; reprocess the byte as plain.
                  res0 = RSP_BAD;
                  if (in_byte_ff == CHR_BACKSLASH) begin
                     count   = 2'd1;
                     mode_in = MODE_ESC;
                  end else begin
                     count   = 2'd2;
                     res1    = data_rsp(in_byte_ff);
                     mode_in = MODE_PLAIN;
                  end
               end
            end
            default: begin
               if (dig.valid) begin
                  // Saturate once any of the top digit's bits would shift out.
                  if (|hex_ff[HEX_BITS-1 -: DIGIT_BITS]) begin
                     hex_in = '1;
                  end else begin
                     hex_in = {hex_ff[HEX_BITS-DIGIT_BITS-1:0], dig.value};
                  end
               end else begin
                  res0   = data_rsp(hex_ff[7:0]);
                  hex_in = '0;
                  if (in_byte_ff == CHR_BACKSLASH) begin
                     count   = 2'd1;
                     mode_in = MODE_ESC;
                  end else begin
                     count   = 2'd2;
                     res1    = data_rsp(in_byte_ff);
                     mode_in = MODE_PLAIN;
                  end
               end
            end
         endcase
      end
   end

   // Emit one result a cycle while the result register is free; retire the byte on its last result.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = in_valid_ff && (count != 2'd0) && out_free;
   assign consume    = in_valid_ff &&
                       ((count == 2'd0) ||
                        (out_free && ({1'b0, phase_ff} == count - 2'd1)));
   assign res_sel    = phase_ff ? res1 : res0;
   // Hold the phase while the second result waits for the output.
   assign phase_in   = (phase_ff || emit) && !consume;
   assign req_tready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         mode_ff      <= MODE_PLAIN;
         at_start_ff  <= 1'b1;
         hex_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load the input register on a transfer, drop it once retired.
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_tdata;
            in_last_ff  <= req_tlast;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
         if (in_valid_ff) begin
            phase_ff <= phase_in;
         end
         // Advance the decode state only when the whole byte is done.
         if (consume) begin
            mode_ff     <= mode_in;
            at_start_ff <= at_start_in;
            hex_ff      <= hex_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res_sel;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.data;
   assign rsp_tuser  = {rsp_ff.bad, rsp_ff.has};
   assign rsp_tlast  = rsp_ff.last;

endmodule

### hdl/sle_checker.sv
// ---------------------------------------------------------------------------
// String literal unescape checker
// Port-level properties of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);
   import sle_pkg::*;

   logic rsp_stall;
   logic end_marker;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign end_marker = rsp_tvalid && !rsp_tuser[0];

   // A stalled result holds its record.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // A record without a character is the end marker and nothing else.
   `ASSERT_IMPLY(a_end_form, clock, reset, end_marker, rsp_tlast && (rsp_tdata == 8'd0) && !rsp_tuser[1], "malformed end marker")

   // The last result of a token never carries a character.
   `ASSERT_IMPLY(a_last_empty, clock, reset, rsp_tvalid && rsp_tlast, !rsp_tuser[0], "last result carries a character")

   // An illegal escape always shows as a space.
   `ASSERT_IMPLY(a_bad_space, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0] && (rsp_tdata == CHR_SPACE), "illegal escape is not a space")

endmodule

bind string_literal_unescape sle_checker u_sle_checker (.*);

### verif/tb_string_literal_unescape.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// String literal unescape testbench
// Feeds quoted string tokens into the decoder and scores every decoded
// character and end marker against a cycle-free behavioural decoder. Starts
// with a handful of hand-built tokens, then streams random tokens of good and
// broken escapes and random bytes, with random gaps and back-pressure.
// ---------------------------------------------------------------------------
module tb_string_literal_unescape;
   import sle_pkg::*;

   localparam int unsigned TOKEN_BYTES  = 650;   // random part, in bytes
   localparam int unsigned IDLE_PERCENT = 35;
   localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no transfer at all
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned REPORT_LIMIT = 10;

   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_APOS   = 8'h27;

   // Decoder state, mirrored from the block's escape handling.
   typedef enum logic [1:0] {
      ST_TEXT,        // plain characters
      ST_SLASH,       // seen a backslash
      ST_SLASH_ZERO,  // seen backslash 0
      ST_HEX          // gathering hex digits after backslash 0 x
   } decode_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } token_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic [1:0] rsp_tuser;          // [0] has_byte, [1] bad_escape
   logic       rsp_tlast;

   // Raw token bytes still to be sent, and decoded characters still owed.
   token_byte_type byte_q[$];
   rsp_type        decoded_q[$];

   // Shadow decoder state.
   decode_state_type dec_state = ST_TEXT;
   logic             dec_open  = 1'b1;
   logic [63:0]      dec_acc   = 64'd0;

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned response_count = 0;
   int unsigned error_count    = 0;
   int unsigned stall_cycles   = 0;
   logic        no_gap;

   logic [7:0] escape_letters [11] = '{CHR_APOS, CHR_DQUOTE, CHR_BACKSLASH,
      "a", "b", "e", "f", "n", "r", "t", "v"};

   always #1 clock = ~clock;

   string_literal_unescape u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Hold both sides busy through a long stretch of the random part.
   assign no_gap = (accepted_count >= 200) && (accepted_count < 330);

   // -------------------------------------------------------------------------
   // Behavioural decoder
   // -------------------------------------------------------------------------
   function automatic void owe_char(input logic [7:0] data, input logic has,
                                    input logic bad, input logic last);
      rsp_type r;
      r.data = data;
      r.has  = has;
      r.bad  = bad;
      r.last = last;
      decoded_q.push_back(r);
   endfunction

   // {valid, code} for the letter after a backslash.
   function automatic logic [8:0] escape_code(input logic [7:0] c);
      case (c)
         CHR_APOS:      return {1'b1, CHR_APOS};
         CHR_DQUOTE:    return {1'b1, CHR_DQUOTE};
         CHR_BACKSLASH: return {1'b1, CHR_BACKSLASH};
         "a":           return {1'b1, 8'd7};
         "b":           return {1'b1, 8'd8};
         "e":           return {1'b1, CHR_ESCAPE};
         "f":           return {1'b1, 8'd12};
         "n":           return {1'b1, 8'd10};
         "r":           return {1'b1, 8'd13};
         "t":           return {1'b1, 8'd9};
         "v":           return {1'b1, 8'd11};
         default:       return 9'd0;
      endcase
   endfunction

   // {valid, nibble} for a hex digit of either case.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      return 5'd0;
   endfunction

   function automatic void clear_decoder();
      dec_state = ST_TEXT;
      dec_open  = 1'b1;
      dec_acc   = 64'd0;
   endfunction

   function automatic void take_text(input logic [7:0] c);
      if (c == CHR_BACKSLASH) dec_state = ST_SLASH;
      else owe_char(c, 1'b1, 1'b0, 1'b0);
   endfunction

   // Work out what one accepted token byte owes on the result side.
   function automatic void decode_token_byte(input logic [7:0] c, input logic fin);
      logic [8:0] esc;
      logic [4:0] nib;
      esc = escape_code(c);
      nib = nibble_of(c);
      // Opening quote: drop it; on its own it is a whole token.
      if (dec_open) begin
         dec_open = 1'b0;
         if (fin) begin
            owe_char(8'd0, 1'b0, 1'b0, 1'b1);
            clear_decoder();
         end
         return;
      end
      // Closing quote: flush any pending escape, then the end marker.
      if (fin) begin
         if (dec_state == ST_SLASH || dec_state == ST_SLASH_ZERO)
            owe_char(CHR_SPACE, 1'b1, 1'b1, 1'b0);
         else if (dec_state == ST_HEX)
            owe_char(dec_acc[7:0], 1'b1, 1'b0, 1'b0);
         owe_char(8'd0, 1'b0, 1'b0, 1'b1);
         clear_decoder();
         return;
      end
      case (dec_state)
         ST_TEXT: begin
            take_text(c);
         end
         ST_SLASH: begin
            if (esc[8]) begin
               owe_char(esc[7:0], 1'b1, 1'b0, 1'b0);
               dec_state = ST_TEXT;
            end else if (c == CHR_ZERO) begin
               dec_state = ST_SLASH_ZERO;
            end else begin
               owe_char(CHR_SPACE, 1'b1, 1'b1, 1'b0);
               dec_state = ST_TEXT;
            end
         end
         ST_SLASH_ZERO: begin
            if (c == CHR_X) begin
               dec_state = ST_HEX;
               dec_acc   = 64'd0;
            end else begin
               // Broken hex prefix: flag it, then treat this byte as text.
               owe_char(CHR_SPACE, 1'b1, 1'b1, 1'b0);
               dec_state = ST_TEXT;
               take_text(c);
            end
         end
         default: begin
            if (nib[4]) begin
               // Saturate once another digit would shift bits out of the top.
               if (dec_acc > ({HEX_BITS{1'b1}} >> DIGIT_BITS))
                  dec_acc = {HEX_BITS{1'b1}};
               else
                  dec_acc = {dec_acc[HEX_BITS-DIGIT_BITS-1:0], nib[3:0]};
            end else begin
               owe_char(dec_acc[7:0], 1'b1, 1'b0, 1'b0);
               dec_state = ST_TEXT;
               dec_acc   = 64'd0;
               take_text(c);
            end
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic void queue_byte(input logic [7:0] data, input logic fin = 1'b0);
      token_byte_type t;
      t.data = data;
      t.fin  = fin;
      byte_q.push_back(t);
      queued_count++;
   endfunction

   function automatic logic [7:0] any_hex_digit();
      int unsigned r;
      r = $urandom_range(0, 21);
      if (r < 10) return CHR_ZERO + 8'(r);
      if (r < 16) return "a" + 8'(r - 10);
      return "A" + 8'(r - 16);
   endfunction

   // One random token: well-formed escapes with random content, mixed with noise.
   function automatic void queue_token();
      int unsigned pieces;
      int unsigned pick;
      int unsigned digits;
      // Occasionally a token that is nothing but its opening quote.
      if ($urandom_range(0, 11) == 0) begin
         queue_byte(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      queue_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : CHR_DQUOTE);
      pieces = $urandom_range(0, 6);
      for (int unsigned p = 0; p < pieces; p++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            queue_byte(8'($urandom_range(0, 255)));
         end else if (pick < 45) begin
            queue_byte(CHR_BACKSLASH);
            queue_byte(escape_letters[$urandom_range(0, 10)]);
         end else if (pick < 53) begin
            queue_byte(CHR_BACKSLASH);
            queue_byte(8'($urandom_range(0, 255)));
         end else if (pick < 60) begin
            queue_byte(CHR_BACKSLASH);
            queue_byte(CHR_ZERO);
            queue_byte(8'($urandom_range(0, 255)));
         end else if (pick < 80) begin
            queue_byte(CHR_BACKSLASH);
            queue_byte(CHR_ZERO);
            queue_byte(CHR_X);
            // Now and then send fifteen to twenty digits, often enough to reach saturation.
            digits = ($urandom_range(0, 6) == 0) ? $urandom_range(15, 20)
                                                 : $urandom_range(0, 4);
            for (int unsigned d = 0; d < digits; d++) queue_byte(any_hex_digit());
         end else if (pick < 88) begin
            // Escape prefix left for the next piece or the closing quote.
            queue_byte(CHR_BACKSLASH);
            if ($urandom_range(0, 1) == 1) queue_byte(CHR_ZERO);
         end else begin
            for (int unsigned n = $urandom_range(1, 3); n > 0; n--)
               queue_byte(8'($urandom_range(0, 255)));
         end
      end
      queue_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : CHR_DQUOTE, 1'b1);
   endfunction

   // -------------------------------------------------------------------------
   // Sequence: reset, directed tokens, drain, random tokens, drain, verdict
   // -------------------------------------------------------------------------
   initial begin
      // Single-byte token: only the end marker comes back.
      queue_byte(CHR_DQUOTE, 1'b1);
      // Zero as opening quote and as text, top byte, a simple escape, an
      // illegal one, backslash 0 without x, hex without digits, a double
      // quote copied through, and a backslash left dangling at the close.
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CHR_BACKSLASH);
      queue_byte("n");
      queue_byte(CHR_BACKSLASH);
      queue_byte("q");
      queue_byte(CHR_BACKSLASH);
      queue_byte(CHR_ZERO);
      queue_byte("y");
      queue_byte(CHR_BACKSLASH);
      queue_byte(CHR_ZERO);
      queue_byte(CHR_X);
      queue_byte("g");
      queue_byte(CHR_DQUOTE);
      queue_byte(CHR_BACKSLASH);
      queue_byte(8'hFF, 1'b1);
      // Hex escape still open at the closing quote.
      queue_byte(CHR_DQUOTE);
      queue_byte(CHR_BACKSLASH);
      queue_byte(CHR_ZERO);
      queue_byte(CHR_X);
      queue_byte("F");
      queue_byte(CHR_DQUOTE, 1'b1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Hold the sender until every owed character has been seen.
      while (accepted_count != queued_count || decoded_q.size() != 0) @(posedge clock);

      while (queued_count < TOKEN_BYTES + 24) queue_token();

      while (accepted_count != queued_count || decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && decoded_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver: present the next token byte once the current one has transferred
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      token_byte_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_token_byte(req_tdata, req_tlast);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_q.size() != 0 &&
                (no_gap || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               t = byte_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= t.data;
               req_tlast  <= t.fin;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: score each result transfer against the oldest owed character
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("ERROR: result %0d arrived with nothing owed: data %02h has %b bad %b last %b",
                           response_count, rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
               error_count <= error_count + 1;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser[0] !== want.has ||
                   rsp_tuser[1] !== want.bad || rsp_tlast !== want.last) begin
                  if (error_count < REPORT_LIMIT)
                     $display("ERROR: result %0d: expected data %02h has %b bad %b last %b, got data %02h has %b bad %b last %b",
                              response_count, want.data, want.has, want.bad, want.last,
                              rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
                  error_count <= error_count + 1;
               end
            end
            response_count <= response_count + 1;
         end
         rsp_tready <= no_gap || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: give up when neither side has transferred for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

endmodule
